// ===== rtl/vtm_pkg.sv =====
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared widths, types and constants of the tensor-magnitude block.
// ----------------------------------------------------------------------------
package vtm_pkg;

  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned GRAD_W = 32;   // one gradient component
  localparam int unsigned DOT_W  = 64;   // diagonal sums and dot magnitudes
  localparam int unsigned NORM_W = 66;   // squared Frobenius norm
  localparam int unsigned PROD_W = 128;  // product of two 64-bit values
  localparam int unsigned TERM_W = 130;  // sum of three products
  localparam int unsigned QUO_W  = 64;   // quotient of the division
  localparam int unsigned ROOT_W = 32;   // square root
  localparam int unsigned SREM_W = 65;   // square-root remainder

  localparam int unsigned NumGrad = 9;
  localparam int unsigned NumProd = 6;

  // Operand pairs of the six 64x64 products: three diagonal cross terms
  // and the squares of the three off-diagonal magnitudes.
  localparam int unsigned PairA [NumProd] = '{0, 0, 1, 3, 4, 5};
  localparam int unsigned PairB [NumProd] = '{1, 2, 2, 3, 4, 5};

  typedef struct packed {
    logic floored;
    logic saturated;
  } flag_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm;
    logic [TERM_W-1:0] bb;
    flag_t             flags;
  } rec_t;

endpackage

// ===== rtl/vtm_front.sv =====
// ----------------------------------------------------------------------------
// vtm_front
// Accepts gradient items, forms the norm and B_beta and classifies each item
// as floored, saturated or to be divided.
// ----------------------------------------------------------------------------
module vtm_front import vtm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [GRAD_W-1:0] grad_i [NumGrad],
  input  logic        [31:0]       floor_i,
  input  logic                     full_i,
  output logic                     push_o,
  output rec_t                     rec_o
);

  logic       en;
  logic [8:0] v_q;

  logic signed [GRAD_W-1:0] g_q    [NumGrad];
  logic signed [DOT_W-1:0]  sq_q   [NumGrad];
  logic signed [DOT_W-1:0]  cr_q   [NumGrad];
  logic        [DOT_W-1:0]  diag_q [3];
  logic signed [NORM_W-1:0] dot_q  [3];
  logic        [DOT_W-1:0]  dm_q   [NumProd];
  logic        [DOT_W-1:0]  pp_q   [NumProd][4];
  logic        [PROD_W-1:0] prod_q [NumProd];
  logic        [TERM_W-1:0] pt_q, nt_q, bb7_q, bb8_q;
  logic        [NORM_W-1:0] norm3_q, norm4_q, norm5_q, norm6_q, norm7_q, norm8_q;
  logic                     fl7_q;
  flag_t                    flag8_q;

  logic [NORM_W-1:0] norm_floor;
  logic [TERM_W-1:0] bb_floor;
  logic [TERM_W-1:0] bb_limit;
  logic              bb_low, bb_high;

  assign en         = !v_q[8] || !full_i;
  assign in_stall_o = !en;
  assign push_o     = v_q[8] && !full_i;

  assign norm_floor = NORM_W'(floor_i) << FRAC_BITS;
  assign bb_floor   = TERM_W'(floor_i) << (3 * FRAC_BITS);
  assign bb_limit   = TERM_W'(norm7_q) << QUO_W;
  assign bb_low     = bb7_q <= bb_floor;
  assign bb_high    = bb7_q >= bb_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[7:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumGrad; k++) begin
        g_q[k] <= grad_i[k];
        sq_q[k] <= g_q[k] * g_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        cr_q[k]     <= g_q[k] * g_q[3+k];
        cr_q[3+k]   <= g_q[k] * g_q[6+k];
        cr_q[6+k]   <= g_q[3+k] * g_q[6+k];
        diag_q[k]   <= $unsigned(sq_q[3*k]) + $unsigned(sq_q[3*k+1])
                       + $unsigned(sq_q[3*k+2]);
        dot_q[k]    <= NORM_W'(cr_q[3*k]) + NORM_W'(cr_q[3*k+1]) + NORM_W'(cr_q[3*k+2]);
        dm_q[k]     <= diag_q[k];
        dm_q[3+k]   <= dot_q[k][NORM_W-1] ? DOT_W'(-dot_q[k]) : DOT_W'(dot_q[k]);
      end
      norm3_q <= NORM_W'(diag_q[0]) + NORM_W'(diag_q[1]) + NORM_W'(diag_q[2]);
      for (int k = 0; k < NumProd; k++) begin
        pp_q[k][0] <= dm_q[PairA[k]][31:0]  * dm_q[PairB[k]][31:0];
        pp_q[k][1] <= dm_q[PairA[k]][31:0]  * dm_q[PairB[k]][63:32];
        pp_q[k][2] <= dm_q[PairA[k]][63:32] * dm_q[PairB[k]][31:0];
        pp_q[k][3] <= dm_q[PairA[k]][63:32] * dm_q[PairB[k]][63:32];
        prod_q[k]  <= {pp_q[k][3], pp_q[k][0]} + (PROD_W'(pp_q[k][1]) << 32)
                      + (PROD_W'(pp_q[k][2]) << 32);
      end
      norm4_q <= norm3_q;
      norm5_q <= norm4_q;
      pt_q    <= TERM_W'(prod_q[0]) + TERM_W'(prod_q[1]) + TERM_W'(prod_q[2]);
      nt_q    <= TERM_W'(prod_q[3]) + TERM_W'(prod_q[4]) + TERM_W'(prod_q[5]);
      norm6_q <= norm5_q;
      fl7_q   <= (pt_q <= nt_q) || (norm6_q <= norm_floor);
      bb7_q   <= pt_q - nt_q;
      norm7_q <= norm6_q;
      flag8_q.floored   <= fl7_q || bb_low;
      flag8_q.saturated <= !fl7_q && !bb_low && bb_high;
      bb8_q   <= bb7_q;
      norm8_q <= norm7_q;
    end
  end

  assign rec_o = '{norm: norm8_q, bb: bb8_q, flags: flag8_q};

endmodule

// ===== rtl/vtm_queue.sv =====
// ----------------------------------------------------------------------------
// vtm_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module vtm_queue import vtm_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t rec_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rec_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

// ===== rtl/vtm_back.sv =====
// ----------------------------------------------------------------------------
// vtm_back
// Pipelined restoring divider and square root, one bit per stage, and the
// output register.
// ----------------------------------------------------------------------------
module vtm_back import vtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  rec_t              rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROOT_W-1:0] magnitude_o,
  output logic              floored_o,
  output logic              saturated_o
);

  logic en;

  logic              dv_q  [QUO_W+1];
  logic [TERM_W-1:0] rem_q [QUO_W+1];
  logic [NORM_W-1:0] dn_q  [QUO_W+1];
  logic [QUO_W-1:0]  dq_q  [QUO_W+1];
  flag_t             dfl_q [QUO_W+1];

  logic              sv_q  [ROOT_W+1];
  logic [SREM_W-1:0] sr_q  [ROOT_W+1];
  logic [ROOT_W-1:0] rt_q  [ROOT_W+1];
  flag_t             sfl_q [ROOT_W+1];

  logic              ov_q;
  logic [ROOT_W-1:0] mag_q;
  flag_t             ofl_q;

  assign en    = !(ov_q && out_stall_i);
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= rec_i.bb;
      dn_q[0]  <= rec_i.norm;
      dq_q[0]  <= '0;
      dfl_q[0] <= rec_i.flags;
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_div
    localparam int unsigned Bit = QUO_W - s;
    logic [TERM_W-1:0] trial;
    logic              ge;

    assign trial = TERM_W'(dn_q[s-1]) << Bit;
    assign ge    = rem_q[s-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else if (en) begin
        dv_q[s] <= dv_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s] <= ge ? rem_q[s-1] - trial : rem_q[s-1];
        dn_q[s]  <= dn_q[s-1];
        dq_q[s]  <= dq_q[s-1] | (QUO_W'(ge) << Bit);
        dfl_q[s] <= dfl_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= dv_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0]  <= SREM_W'(dq_q[QUO_W]);
      rt_q[0]  <= '0;
      sfl_q[0] <= dfl_q[QUO_W];
    end
  end

  for (genvar t = 1; t <= ROOT_W; t++) begin : g_sqrt
    localparam int unsigned Bit = ROOT_W - t;
    logic [SREM_W-1:0] trial;
    logic              ge;

    assign trial = (SREM_W'(rt_q[t-1]) << (Bit + 1)) | (SREM_W'(1) << (2 * Bit));
    assign ge    = sr_q[t-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[t] <= 1'b0;
      end else if (en) begin
        sv_q[t] <= sv_q[t-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[t]  <= ge ? sr_q[t-1] - trial : sr_q[t-1];
        rt_q[t]  <= rt_q[t-1] | (ROOT_W'(ge) << Bit);
        sfl_q[t] <= sfl_q[t-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= sv_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ofl_q <= sfl_q[ROOT_W];
      if (sfl_q[ROOT_W].floored) begin
        mag_q <= '0;
      end else if (sfl_q[ROOT_W].saturated) begin
        mag_q <= '1;
      end else begin
        mag_q <= rt_q[ROOT_W];
      end
    end
  end

  assign out_valid_o = ov_q;
  assign magnitude_o = mag_q;
  assign floored_o   = ofl_q.floored;
  assign saturated_o = ofl_q.saturated;

endmodule

// ===== rtl/vreman_tensor_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// vreman_tensor_magnitude_top
// Vreman operator magnitude sqrt(B_beta / |alpha|^2) for one grid cell per item.
//
//   channel   valid        stall        payload
//   input     in_valid_i   in_stall_o   du_dx_i .. dw_dz_i
//   output    out_valid_o  out_stall_i  magnitude_o, floored_o, saturated_o
//   config    cfg_we_i     -            cfg_wdata_i (positivity floor)
//
// One item is accepted per cycle while in_stall_o is low; the back part holds
// the 64-stage divider and the 32-stage square root.
// A four-entry queue separates the front pipeline from the back pipeline.
// An output stall holds the back part; the front stalls only when the queue
// is full. Reset clears all valid bits and sets the floor to one.
// ----------------------------------------------------------------------------
module vreman_tensor_magnitude_top import vtm_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic        [31:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [GRAD_W-1:0] du_dx_i,
  input  logic signed [GRAD_W-1:0] du_dy_i,
  input  logic signed [GRAD_W-1:0] du_dz_i,
  input  logic signed [GRAD_W-1:0] dv_dx_i,
  input  logic signed [GRAD_W-1:0] dv_dy_i,
  input  logic signed [GRAD_W-1:0] dv_dz_i,
  input  logic signed [GRAD_W-1:0] dw_dx_i,
  input  logic signed [GRAD_W-1:0] dw_dy_i,
  input  logic signed [GRAD_W-1:0] dw_dz_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic        [ROOT_W-1:0] magnitude_o,
  output logic                     floored_o,
  output logic                     saturated_o
);

  logic [31:0]              floor_q;
  logic signed [GRAD_W-1:0] grad [NumGrad];
  rec_t                     push_rec, pop_rec;
  logic                     push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= 32'd1;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  assign grad = '{du_dx_i, du_dy_i, du_dz_i,
                  dv_dx_i, dv_dy_i, dv_dz_i,
                  dw_dx_i, dw_dy_i, dw_dz_i};

  vtm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .grad_i     (grad),
    .floor_i    (floor_q),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  vtm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (pop_rec)
  );

  vtm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .magnitude_o (magnitude_o),
    .floored_o   (floored_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== sim/vreman_tensor_magnitude_top_tb.sv =====
// ----------------------------------------------------------------------------
// vreman_tensor_magnitude_top_tb
// Self-checking bench for the tensor-magnitude block: a table of directed
// cells, then random cells under several floor settings. Every result is
// compared field by field with a table value or exact wide-integer prediction.
// ----------------------------------------------------------------------------
module vreman_tensor_magnitude_top_tb;
  import vtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frac = 16;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait = 150;
  localparam int unsigned NumRandom = 1400;
  localparam logic signed [31:0] GMin = 32'sh80000000;
  localparam logic signed [31:0] GMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] One  = 32'sh00010000;

  typedef logic signed [31:0] grad_t [NumGrad];

  typedef struct {
    logic [31:0] magnitude;
    logic        floored;
    logic        saturated;
  } magres_t;

  typedef struct {
    grad_t   g;
    bit      typed;
    magres_t res;
  } cell_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] grad_in [NumGrad];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] magnitude_o;
  logic floored_o;
  logic saturated_o;

  logic [31:0] floor_val = 32'd1;
  magres_t     pending_mag [$];
  cell_row_t   sent_rows [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_in = 0, n_out = 0, n_floored = 0, n_sat = 0;
  bit          hold_req = 1'b0;
  bit          idle_mode = 1'b1;

  initial begin
    for (int i = 0; i < NumGrad; i++) grad_in[i] = '0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vreman_tensor_magnitude_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .du_dx_i(grad_in[0]), .du_dy_i(grad_in[1]), .du_dz_i(grad_in[2]),
    .dv_dx_i(grad_in[3]), .dv_dy_i(grad_in[4]), .dv_dz_i(grad_in[5]),
    .dw_dx_i(grad_in[6]), .dw_dy_i(grad_in[7]), .dw_dz_i(grad_in[8]),
    .out_valid_o, .out_stall_i, .magnitude_o, .floored_o, .saturated_o
  );

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bits;
    res = '0;
    bits = 64'h1 << 62;
    while (bits > x) bits >>= 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] dot_mag(grad_t g, int a, int b);
    logic signed [65:0] s;
    s = 0;
    for (int k = 0; k < 3; k++) s += 66'(g[a + k]) * 66'(g[b + k]);
    return (s < 0) ? 64'(-s) : 64'(s);
  endfunction

  function automatic magres_t vreman_magnitude(grad_t g, logic [31:0] fl);
    logic [191:0] dg [3];
    logic [191:0] o12, o13, o23, norm, pterm, nterm, bb, q;
    magres_t r;
    for (int j = 0; j < 3; j++) begin
      dg[j] = '0;
      for (int k = 0; k < 3; k++)
        dg[j] += 192'(64'(66'(g[3*j+k]) * 66'(g[3*j+k])));
    end
    o12 = 192'(dot_mag(g, 0, 3));
    o13 = 192'(dot_mag(g, 0, 6));
    o23 = 192'(dot_mag(g, 3, 6));
    norm = dg[0] + dg[1] + dg[2];
    pterm = dg[0] * dg[1] + dg[0] * dg[2] + dg[1] * dg[2];
    nterm = o12 * o12 + o13 * o13 + o23 * o23;
    r = '{32'd0, 1'b1, 1'b0};
    if (pterm <= nterm || norm <= (192'(fl) << Frac)) return r;
    bb = pterm - nterm;
    if (bb <= (192'(fl) << (3 * Frac))) return r;
    if (bb >= (norm << 64)) return '{32'hFFFFFFFF, 1'b0, 1'b1};
    q = bb / norm;
    r = '{32'(isqrt(q[63:0])), 1'b0, 1'b0};
    return r;
  endfunction

  function automatic grad_t random_cell();
    grad_t g;
    logic signed [31:0] ext [5];
    logic signed [31:0] a [3], b [3];
    int unsigned kind;
    ext = '{GMin, GMax, 32'sd0, -32'sd1, 32'sd1};
    kind = $urandom_range(0, 6);
    for (int i = 0; i < NumGrad; i++) begin
      case (kind)
        0: g[i] = $urandom;
        1: g[i] = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        2: g[i] = ext[$urandom_range(0, 4)];
        3: g[i] = $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
        4: g[i] = (i % 4 == 0) ? $signed($urandom) : 32'sd0;
        default: g[i] = $signed($urandom) >>> $urandom_range(0, 31);
      endcase
    end
    if (kind == 5) begin
      for (int j = 0; j < 3; j++) begin
        a[j] = $signed($urandom_range(0, 511)) - 256;
        b[j] = $signed($urandom_range(0, 65535)) - 32768;
      end
      for (int i = 0; i < NumGrad; i++) g[i] = a[i / 3] * b[i % 3];
    end
    return g;
  endfunction

  always @(posedge clk_i) begin
    magres_t e;
    cell_row_t row;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
        $display("vreman_tensor_magnitude_top test failed");
        $finish;
      end
      if (in_valid_i && !in_stall_o) begin
        row = sent_rows.pop_front();
        pending_mag.push_back(row.typed ? row.res : vreman_magnitude(row.g, floor_val));
        n_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        n_floored += floored_o;
        n_sat += saturated_o;
        if (pending_mag.size() == 0) begin
          $error("result with no item pending: magnitude %h", magnitude_o);
          errors++;
        end else begin
          e = pending_mag.pop_front();
          if (magnitude_o !== e.magnitude) begin
            $error("magnitude: expected %h, actual %h", e.magnitude, magnitude_o);
            errors++;
          end
          if (floored_o !== e.floored) begin
            $error("floored: expected %b, actual %b", e.floored, floored_o);
            errors++;
          end
          if (saturated_o !== e.saturated) begin
            $error("saturated: expected %b, actual %b", e.saturated, saturated_o);
            errors++;
          end
        end
      end
    end
  end

  initial begin : receiver
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      n = idle_mode ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_cell(cell_row_t row);
    int unsigned gap;
    sent_rows.push_back(row);
    for (int i = 0; i < NumGrad; i++) grad_in[i] <= row.g[i];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = idle_mode ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_mag.size() != 0 || sent_rows.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_floor(logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    floor_val = v;
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    cell_row_t table_rows [$];
    cell_row_t row;
    grad_t g;
    logic [31:0] floors [5];
    floors = '{32'd0, 32'hFFFFFFFF, 32'h00010000, 32'd1, 32'd0};

    for (int i = 0; i < NumGrad; i++) g[i] = '0;
    table_rows.push_back('{g, 1'b1, '{32'd0, 1'b1, 1'b0}});
    foreach (g[i]) g[i] = (i % 4 == 0) ? One : 32'sd0;
    table_rows.push_back('{g, 1'b1, '{32'h00010000, 1'b0, 1'b0}});
    foreach (g[i]) g[i] = GMin;
    table_rows.push_back('{g, 1'b1, '{32'd0, 1'b1, 1'b0}});
    foreach (g[i]) g[i] = GMax;
    table_rows.push_back('{g, 1'b1, '{32'd0, 1'b1, 1'b0}});
    foreach (g[i]) g[i] = (i % 4 == 0) ? GMax : 32'sd0;
    table_rows.push_back('{g, 1'b0, '{0, 0, 0}});
    foreach (g[i]) g[i] = (i % 4 == 0) ? GMin : 32'sd0;
    table_rows.push_back('{g, 1'b0, '{0, 0, 0}});
    foreach (g[i]) g[i] = (i % 4 == 0) ? GMin : GMax;
    table_rows.push_back('{g, 1'b0, '{0, 0, 0}});
    foreach (g[i]) g[i] = (i % 2) ? -32'sd1 : 32'sd1;
    table_rows.push_back('{g, 1'b0, '{0, 0, 0}});
    for (int k = 0; k < NumGrad; k++) begin
      foreach (g[i]) g[i] = (i == k) ? GMax : ((i % 4 == 0) ? One : 32'sd0);
      table_rows.push_back('{g, 1'b0, '{0, 0, 0}});
    end
    foreach (g[i]) g[i] = (i % 4 == 0) ? 32'sd1 : 32'sd0;
    table_rows.push_back('{g, 1'b0, '{0, 0, 0}});
    foreach (g[i]) g[i] = (i % 4 == 0) ? 32'sh100 : 32'sd0;
    table_rows.push_back('{g, 1'b0, '{0, 0, 0}});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[r]) send_cell(table_rows[r]);

    for (int ph = 0; ph < 5; ph++) begin
      set_floor(ph == 4 ? $urandom : floors[ph]);
      idle_mode = (ph != 2);
      for (int n = 0; n < NumRandom / 5; n++) begin
        if (ph == 1 && n == 50) hold_req = 1'b1;
        if (ph == 3 && n == 100) drain();
        row = '{random_cell(), 1'b0, '{0, 0, 0}};
        send_cell(row);
      end
    end
    drain();

    $display("Checked %0d of %0d cells over six floor settings.", n_out, n_in);
    $display("Floored results: %0d, saturated results: %0d.", n_floored, n_sat);
    if (errors == 0) begin
      $display("vreman_tensor_magnitude_top test passed");
    end else begin
      $display("vreman_tensor_magnitude_top test failed");
    end
    $finish;
  end

endmodule
